@@ hw/rtl/spru_pkg.sv @@
// Shared types and constants for the stream pattern reverse/replace unit.
// No dependencies; used by every file in hw/rtl.
package spru_pkg;

  localparam int unsigned MAX_PATTERN = 16;  // largest supported pattern, in bytes
  localparam int unsigned CFG_W       = 64;  // config data width
  localparam int unsigned CFG_IDX_W   = 2;   // config register index width
  localparam int unsigned LEN_W       = 5;   // pattern_length register width

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // Per-cycle control from the sequencer to the cell chain
  typedef struct packed {
    logic busy;    // stored item still has work pending
    logic step;    // window advances this cycle
    logic append;  // input item written at the fill position
    logic shift;   // oldest byte leaves, chain moves one cell down
    logic hit;     // window matched, load reversed pattern
    logic last;    // leaving byte is the final one of the text
  } ctl_t;

endpackage

@@ hw/rtl/spru_cell.sv @@
// One window cell: holds a text byte, compares it with its pattern byte,
// and hands data down the chain. Depends on spru_pkg.
module spru_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned CntW  = 5
) (
  input  logic            clk_i,
  input  spru_pkg::ctl_t  ctl_i,
  input  logic [CntW-1:0] fill_i,
  input  logic [7:0]      in_byte_i,
  input  logic [7:0]      pat_i,
  input  logic            use_i,
  input  logic [7:0]      next_byte_i,
  input  logic [7:0]      next_rev_i,
  output logic [7:0]      byte_o,
  output logic            match_o
);

  logic [7:0] byte_q, byte_d;

  // new byte lands in the first free cell
  assign byte_o  = (ctl_i.append && (fill_i == CntW'(Index))) ? in_byte_i : byte_q;
  assign match_o = ~use_i | (byte_o == pat_i);

  always_comb begin
    byte_d = byte_q;
    if (ctl_i.step) begin
      if (ctl_i.shift) begin
        byte_d = ctl_i.hit ? next_rev_i : next_byte_i;
      end else begin
        byte_d = byte_o;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

@@ hw/rtl/spru_ctrl.sv @@
// Window sequencer: fill count, skip counter, compare and drain control.
// Depends on spru_pkg.
module spru_ctrl #(
  parameter int unsigned CntW = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  input  logic            out_free_i,
  input  logic            match_i,
  input  logic [CntW-1:0] len_i,
  output logic            in_stall_o,
  output spru_pkg::ctl_t  ctl_o,
  output logic [CntW-1:0] fill_o
);

  logic            busy_q, busy_d;
  logic            cmp_q, cmp_d;
  logic            last_q, last_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] skip_q, skip_d;

  logic            accept, step, cur_cmp, cur_last;
  logic            surplus, do_cmp, hit, emit, emit_last, done;
  logic [CntW-1:0] n;

  assign in_stall_o = busy_q | ~out_free_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign step       = accept | (busy_q & out_free_i);

  // bytes in the window this cycle, new item included
  assign n        = accept ? cnt_q + CntW'(1) : cnt_q;
  assign cur_cmp  = accept | cmp_q;
  assign cur_last = accept ? in_last_i : last_q;

  assign surplus   = n > len_i;
  assign do_cmp    = ~surplus & cur_cmp;
  assign hit       = do_cmp & (skip_q == '0) & (n == len_i) & match_i;
  assign emit      = surplus | cur_last | (cur_cmp & (n == len_i));
  assign emit_last = ~surplus & cur_last & (n == CntW'(1));
  assign done      = ~surplus & (~cur_last | (n == CntW'(1)));

  always_comb begin
    busy_d = busy_q;
    cmp_d  = cmp_q;
    last_d = last_q;
    cnt_d  = cnt_q;
    skip_d = skip_q;
    if (step) begin
      busy_d = ~done;
      cmp_d  = cur_cmp & ~do_cmp;
      last_d = cur_last;
      cnt_d  = n - CntW'(emit);
      if (do_cmp) begin
        if (cur_last) begin
          skip_d = '0;
        end else if (hit) begin
          skip_d = len_i - CntW'(1);
        end else if (skip_q != '0) begin
          skip_d = skip_q - CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cmp_q  <= 1'b0;
      last_q <= 1'b0;
      cnt_q  <= '0;
      skip_q <= '0;
    end else begin
      busy_q <= busy_d;
      cmp_q  <= cmp_d;
      last_q <= last_d;
      cnt_q  <= cnt_d;
      skip_q <= skip_d;
    end
  end

  assign ctl_o.busy   = busy_q;
  assign ctl_o.step   = step;
  assign ctl_o.append = accept;
  assign ctl_o.shift  = step & emit;
  assign ctl_o.hit    = step & hit;
  assign ctl_o.last   = emit_last;
  assign fill_o       = cnt_q;

endmodule

@@ hw/rtl/stream_pattern_reverse_replace_unit.sv @@
// Top level of the stream pattern reverse/replace unit: config registers,
// cell chain, sequencer and output register. Depends on spru_pkg,
// spru_cell and spru_ctrl.
// Usage:
//   Text bytes enter on the in_* channel (valid/stall), rewritten bytes
//   leave on the out_* channel (valid/stall), one byte per item. Every
//   occurrence of the configured pattern (leftmost, non-overlapping) is
//   replaced by the pattern reversed.
//   The user writes config registers through cfg_* only while the stream is
//   idle (0 pattern_low, 1 pattern_high, 2 pattern_length); not enforced.
//   Latency: with pattern length L, a byte enters the output register at the
//   accept edge of the item L-1 items behind it; the first L-1 bytes stay held.
//   Throughput: one item per cycle in steady state, set by the combinational
//   window compare across the cell chain. After an item with in_last set the
//   input stalls while the up to L-1 held bytes drain, one per cycle while
//   the output is free; the final one carries out_last. After pattern_length
//   is lowered, the next item stalls the input while surplus held bytes drain.
//   Receiver stall: the output register holds its item, and the input
//   stalls in the same cycle while the output register is full and stalled.
//   Reset: window empty, skip counter clear, pattern zero, length one.
module stream_pattern_reverse_replace_unit #(
  parameter int unsigned MaxPattern = spru_pkg::MAX_PATTERN
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // text in
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  spru_pkg::in_item_t                 in_item_i,
  // text out
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output spru_pkg::out_item_t                out_item_o,
  // config writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [spru_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [spru_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned CntW = $clog2(MaxPattern + 1);

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  logic [spru_pkg::CFG_W-1:0] pattern_low_q, pattern_high_q;
  logic [spru_pkg::LEN_W-1:0] pattern_length_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_low_q    <= '0;
      pattern_high_q   <= '0;
      pattern_length_q <= spru_pkg::LEN_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        spru_pkg::CFG_PATTERN_LOW:    pattern_low_q    <= cfg_data_i;
        spru_pkg::CFG_PATTERN_HIGH:   pattern_high_q   <= cfg_data_i;
        spru_pkg::CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data_i[spru_pkg::LEN_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pattern views: length clamped to 1..MaxPattern, forward bytes for the
  // compare, reversed bytes for the replacement.
  // ---------------------------------------------------------------------
  logic [CntW-1:0]             eff_len;
  logic [15:0][7:0]            pat16;
  logic [MaxPattern:0][7:0]    rev;   // one extra zero entry past the chain end

  assign pat16 = {pattern_high_q, pattern_low_q};

  always_comb begin
    if (pattern_length_q == '0) begin
      eff_len = CntW'(1);
    end else if (pattern_length_q > spru_pkg::LEN_W'(MaxPattern)) begin
      eff_len = CntW'(MaxPattern);
    end else begin
      eff_len = CntW'(pattern_length_q);
    end
  end

  always_comb begin
    rev = '0;
    for (int j = 0; j < MaxPattern; j++) begin
      if (j < int'(eff_len)) begin
        rev[j] = pat16[4'(int'(eff_len) - 1 - j)];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  spru_pkg::ctl_t  ctl;
  logic [CntW-1:0] fill;
  logic            out_free;
  logic            match_all;

  spru_ctrl #(
    .CntW (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_item_i.in_last),
    .out_free_i (out_free),
    .match_i    (match_all),
    .len_i      (eff_len),
    .in_stall_o (in_stall_o),
    .ctl_o      (ctl),
    .fill_o     (fill)
  );

  // ---------------------------------------------------------------------
  // Cell chain, cell 0 holds the oldest byte
  // ---------------------------------------------------------------------
  logic [MaxPattern:0][7:0]  cell_byte;
  logic [MaxPattern-1:0]     cell_match;

  assign cell_byte[MaxPattern] = '0;
  assign match_all             = &cell_match;

  for (genvar i = 0; i < MaxPattern; i++) begin : g_cell
    spru_cell #(
      .Index (i),
      .CntW  (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .fill_i      (fill),
      .in_byte_i   (in_item_i.in_byte),
      .pat_i       (pat16[i]),
      .use_i       (CntW'(i) < eff_len),
      .next_byte_i (cell_byte[i+1]),
      .next_rev_i  (rev[i+1]),
      .byte_o      (cell_byte[i]),
      .match_o     (cell_match[i])
    );
  end

  // ---------------------------------------------------------------------
  // Output register; on a hit the leaving byte is the last pattern byte
  // ---------------------------------------------------------------------
  logic                out_valid_q;
  spru_pkg::out_item_t out_item_q, out_item_d;

  assign out_free            = ~out_valid_q | ~out_stall_i;
  assign out_item_d.out_byte = ctl.hit ? rev[0] : cell_byte[0];
  assign out_item_d.out_last = ctl.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.shift) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.shift) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // a final text byte always puts at least one byte in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_item_i.in_last) |=> out_valid_q)
    else $error("final item produced no output byte");

  // once the final byte is waiting, nothing of the item is left to drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.out_last) |-> !ctl.busy)
    else $error("window still draining behind final byte");

  // a replacement always coincides with a byte leaving the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.hit |-> (ctl.step && ctl.shift && out_free))
    else $error("replacement without output slot");
`endif

endmodule
